[hw/rtl/mpsc_pkg.sv]
// ----------------------------------------------------------------------------
// MDIO PHY scan classifier package
// Shared beat types, verdict codes and scan constants for the classifier.
// ----------------------------------------------------------------------------
package mpsc_pkg;

   // Default scan geometry.
   localparam int NUM_ADDRESSES_DEFAULT     = 32;
   localparam int READS_PER_ADDRESS_DEFAULT = 4;

   // Most register 2 reads that an input beat carries.
   localparam int MAX_READS = 4;

   // Field constants.
   localparam logic [15:0] ID_FLOATING    = 16'hFFFF;
   localparam logic [15:0] ID_ZERO        = 16'h0000;
   localparam logic [7:0]  NO_ADDRESS     = 8'hFF;
   localparam logic [5:0]  COUNT_MAX      = 6'd63;
   localparam logic [7:0]  TOTAL_MAX      = 8'hFF;
   localparam logic [15:0] EXPECTED_RESET = 16'd7;

   // Configuration port geometry and register indexes.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_EXPECTED_ID_HIGH = 1'b0;

   // Verdict codes.
   typedef enum logic [3:0] {
      VERDICT_OK          = 4'd0,
      VERDICT_AMBIGUOUS   = 4'd1,
      VERDICT_OTHER_ID    = 4'd2,
      VERDICT_MULTI_OTHER = 4'd3,
      VERDICT_UNSTABLE    = 4'd4,
      VERDICT_TIMEOUT     = 4'd5,
      VERDICT_FLOATING    = 4'd6,
      VERDICT_LOW         = 4'd7,
      VERDICT_TRIVIAL_MIX = 4'd8
   } verdict_type;

   // Priority of the first-address slots held by one address.
   typedef enum logic [1:0] {
      PRIO_NONE      = 2'd0,
      PRIO_UNSTABLE  = 2'd1,
      PRIO_OTHER     = 2'd2,
      PRIO_CANDIDATE = 2'd3
   } prio_type;

   // One input beat: the reads of one PHY address.
   typedef struct packed {
      logic [4:0]  phy_address;
      logic [15:0] id_read_a;
      logic [15:0] id_read_b;
      logic [15:0] id_read_c;
      logic [15:0] id_read_d;
      logic [3:0]  id_read_timeouts;
      logic [15:0] id_low_value;
      logic        id_low_timeout;
      logic        final_address;
   } req_type;

   // One result beat: the verdict of a whole scan.
   typedef struct packed {
      logic [3:0]  verdict;
      logic [7:0]  chosen_address;
      logic [15:0] chosen_id_high;
      logic [15:0] chosen_id_low;
      logic [5:0]  candidate_count;
      logic [7:0]  timed_out_reads;
      logic [31:0] floating_mask;
      logic [31:0] zero_mask;
      logic [31:0] unstable_mask;
      logic [31:0] other_mask;
      logic [31:0] candidate_mask;
      logic [31:0] timeout_mask;
   } rsp_type;

   // Saturating increment of a class count.
   function automatic logic [5:0] count_up(input logic [5:0] value);
      logic [5:0] result;
      result = (value == COUNT_MAX) ? value : value + 6'd1;
      return result;
   endfunction

endpackage

[hw/rtl/mdio_phy_scan_classifier_core.sv]
// The result beat is offered after the finished scan passes stage one and the output register.
// Throughput: one address beat per cycle unless req_stall; the ID pair RAM, one write per cycle.
// A result held by rsp_stall and a second finished scan in stage one together stall the input.
// Reset clears all scan state and sets expected_id_high to 7; the ID pair RAM needs no
// clearing because an entry is read only after it was written in the same scan.
// ----------------------------------------------------------------------------
// MDIO PHY scan classifier core
// Classifies one PHY address per beat into timeout, unstable, floating, zero
// or other (and candidate), keeps class masks and counts, and on the final
// address applies the verdict ladder and returns one result beat.
// ----------------------------------------------------------------------------
module mdio_phy_scan_classifier_core #(
   parameter int NUM_ADDRESSES     = mpsc_pkg::NUM_ADDRESSES_DEFAULT,
   parameter int READS_PER_ADDRESS = mpsc_pkg::READS_PER_ADDRESS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // Input channel.
   input  logic                            req_valid,
   output logic                            req_stall,
   input  mpsc_pkg::req_type               req_data,
   // Result channel.
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output mpsc_pkg::rsp_type               rsp_data,
   // Configuration port.
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [mpsc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mpsc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [mpsc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   localparam int NREADS = (READS_PER_ADDRESS > mpsc_pkg::MAX_READS) ?
                           mpsc_pkg::MAX_READS : READS_PER_ADDRESS;
   localparam int AW = (NUM_ADDRESSES > 1) ? $clog2(NUM_ADDRESSES) : 1;
   localparam logic [5:0] NUM_ADDR_6 = 6'(NUM_ADDRESSES);

   // ------------------------------------------------------------------
   // Configuration register.
   // ------------------------------------------------------------------
   logic [15:0] expected_ff;
   logic        csr_write;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= mpsc_pkg::EXPECTED_RESET;
      end else if (csr_write && (csr_paddr[2] == mpsc_pkg::CSR_IDX_EXPECTED_ID_HIGH)) begin
         expected_ff <= csr_pwdata[15:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == mpsc_pkg::CSR_IDX_EXPECTED_ID_HIGH) ?
                       {16'd0, expected_ff} : '0;

   // ------------------------------------------------------------------
   // Scan state.
   // ------------------------------------------------------------------
   logic [31:0] float_mask_ff, zero_mask_ff, unst_mask_ff;
   logic [31:0] other_mask_ff, cand_mask_ff, tmo_mask_ff;
   logic [31:0] float_mask_in, zero_mask_in, unst_mask_in;
   logic [31:0] other_mask_in, cand_mask_in, tmo_mask_in;
   logic [5:0]  float_cnt_ff, zero_cnt_ff, unst_cnt_ff;
   logic [5:0]  other_cnt_ff, cand_cnt_ff, tmo_cnt_ff;
   logic [5:0]  float_cnt_in, zero_cnt_in, unst_cnt_in;
   logic [5:0]  other_cnt_in, cand_cnt_in, tmo_cnt_in;
   logic [7:0]  first_cand_ff, first_other_ff, first_unst_ff;
   logic [7:0]  first_cand_in, first_other_in, first_unst_in;
   logic [7:0]  total_ff, total_in;

   // ------------------------------------------------------------------
   // Pipeline control: a finishing scan waits in stage one for its RAM read.
   // ------------------------------------------------------------------
   logic    accept;
   logic    s1_move;
   logic    s1_valid_ff, s1_valid_in;
   logic    rsp_valid_ff, rsp_valid_in;

   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // ------------------------------------------------------------------
   // Classification of the incoming address.
   // ------------------------------------------------------------------
   logic [15:0] reads [mpsc_pkg::MAX_READS];
   logic        in_range;
   logic        stable;
   logic [2:0]  nto;
   logic        is_tmo, is_unst, is_float, is_zero, is_other, is_cand;
   logic [31:0] addr_bit;
   logic [7:0]  addr_ext;
   logic [31:0] pair;
   logic [8:0]  total_sum;

   assign reads[0] = req_data.id_read_a;
   assign reads[1] = req_data.id_read_b;
   assign reads[2] = req_data.id_read_c;
   assign reads[3] = req_data.id_read_d;

   always_comb begin
      stable = 1'b1;
      nto    = {2'd0, req_data.id_low_timeout};
      for (int i = 0; i < mpsc_pkg::MAX_READS; i++) begin
         if (i < NREADS) begin
            if (req_data.id_read_timeouts[i]) begin
               nto = nto + 3'd1;
            end
            if (reads[i] != reads[0]) begin
               stable = 1'b0;
            end
         end
      end
   end

   assign in_range  = accept && ({1'b0, req_data.phy_address} < NUM_ADDR_6);
   assign is_tmo    = in_range && (nto != 3'd0);
   assign is_unst   = in_range && (nto == 3'd0) && !stable;
   assign is_float  = in_range && (nto == 3'd0) && stable &&
                      (reads[0] == mpsc_pkg::ID_FLOATING);
   assign is_zero   = in_range && (nto == 3'd0) && stable &&
                      (reads[0] == mpsc_pkg::ID_ZERO);
   assign is_other  = in_range && (nto == 3'd0) && stable &&
                      (reads[0] != mpsc_pkg::ID_FLOATING) && (reads[0] != mpsc_pkg::ID_ZERO);
   assign is_cand   = is_other && (reads[0] == expected_ff);
   assign addr_bit  = 32'd1 << req_data.phy_address;
   assign addr_ext  = {3'd0, req_data.phy_address};
   assign pair      = {reads[NREADS-1], req_data.id_low_value};
   assign total_sum = {1'b0, total_ff} + {6'd0, nto};

   // Next scan state including this beat.
   always_comb begin
      float_mask_in = float_mask_ff | (is_float ? addr_bit : 32'd0);
      zero_mask_in  = zero_mask_ff  | (is_zero  ? addr_bit : 32'd0);
      unst_mask_in  = unst_mask_ff  | (is_unst  ? addr_bit : 32'd0);
      other_mask_in = other_mask_ff | (is_other ? addr_bit : 32'd0);
      cand_mask_in  = cand_mask_ff  | (is_cand  ? addr_bit : 32'd0);
      tmo_mask_in   = tmo_mask_ff   | (is_tmo   ? addr_bit : 32'd0);
      float_cnt_in  = is_float ? mpsc_pkg::count_up(float_cnt_ff) : float_cnt_ff;
      zero_cnt_in   = is_zero  ? mpsc_pkg::count_up(zero_cnt_ff)  : zero_cnt_ff;
      unst_cnt_in   = is_unst  ? mpsc_pkg::count_up(unst_cnt_ff)  : unst_cnt_ff;
      other_cnt_in  = is_other ? mpsc_pkg::count_up(other_cnt_ff) : other_cnt_ff;
      cand_cnt_in   = is_cand  ? mpsc_pkg::count_up(cand_cnt_ff)  : cand_cnt_ff;
      tmo_cnt_in    = is_tmo   ? mpsc_pkg::count_up(tmo_cnt_ff)   : tmo_cnt_ff;
      total_in      = total_ff;
      if (in_range) begin
         total_in = (total_sum > {1'b0, mpsc_pkg::TOTAL_MAX}) ?
                    mpsc_pkg::TOTAL_MAX : total_sum[7:0];
      end
      first_cand_in  = first_cand_ff;
      first_other_in = first_other_ff;
      first_unst_in  = first_unst_ff;
      if (is_cand && (first_cand_ff == mpsc_pkg::NO_ADDRESS)) begin
         first_cand_in = addr_ext;
      end
      if (is_other && (first_other_ff == mpsc_pkg::NO_ADDRESS)) begin
         first_other_in = addr_ext;
      end
      if (is_unst && (first_unst_ff == mpsc_pkg::NO_ADDRESS)) begin
         first_unst_in = addr_ext;
      end
   end

   // ------------------------------------------------------------------
   // ID pair RAM, one entry per address. An entry is written only when the
   // beat opens a first-address slot of higher priority than any slot the
   // address already holds, so it always carries the pair of the best slot
   // of its address, which is the slot the verdict ladder picks.
   // ------------------------------------------------------------------
   mpsc_pkg::prio_type new_prio, held_prio;
   logic               ram_we;
   logic               ram_re;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic [31:0]        ram_rdata;

   always_comb begin
      new_prio = mpsc_pkg::PRIO_NONE;
      if (first_unst_in != first_unst_ff) begin
         new_prio = mpsc_pkg::PRIO_UNSTABLE;
      end
      if (first_other_in != first_other_ff) begin
         new_prio = mpsc_pkg::PRIO_OTHER;
      end
      if (first_cand_in != first_cand_ff) begin
         new_prio = mpsc_pkg::PRIO_CANDIDATE;
      end
      held_prio = mpsc_pkg::PRIO_NONE;
      if (first_unst_ff == addr_ext) begin
         held_prio = mpsc_pkg::PRIO_UNSTABLE;
      end
      if (first_other_ff == addr_ext) begin
         held_prio = mpsc_pkg::PRIO_OTHER;
      end
      if (first_cand_ff == addr_ext) begin
         held_prio = mpsc_pkg::PRIO_CANDIDATE;
      end
   end

   assign ram_we    = new_prio > held_prio;
   assign ram_waddr = req_data.phy_address[AW-1:0];

   // ------------------------------------------------------------------
   // Verdict ladder on the state that includes the final beat.
   // ------------------------------------------------------------------
   mpsc_pkg::verdict_type verdict;
   logic [7:0]            sel;
   logic                  use_slot;
   logic                  final_beat;

   assign final_beat = accept && req_data.final_address;

   always_comb begin
      use_slot = 1'b1;
      sel      = first_cand_in;
      if (cand_cnt_in == 6'd1) begin
         verdict = mpsc_pkg::VERDICT_OK;
      end else if (cand_cnt_in > 6'd1) begin
         verdict = mpsc_pkg::VERDICT_AMBIGUOUS;
      end else if (other_cnt_in == 6'd1) begin
         verdict = mpsc_pkg::VERDICT_OTHER_ID;
         sel     = first_other_in;
      end else if (other_cnt_in > 6'd1) begin
         verdict = mpsc_pkg::VERDICT_MULTI_OTHER;
         sel     = first_other_in;
      end else if (unst_cnt_in != 6'd0) begin
         verdict = mpsc_pkg::VERDICT_UNSTABLE;
         sel     = first_unst_in;
      end else begin
         use_slot = 1'b0;
         sel      = mpsc_pkg::NO_ADDRESS;
         if (tmo_cnt_in != 6'd0) begin
            verdict = mpsc_pkg::VERDICT_TIMEOUT;
         end else if (float_cnt_in == NUM_ADDR_6) begin
            verdict = mpsc_pkg::VERDICT_FLOATING;
         end else if (zero_cnt_in == NUM_ADDR_6) begin
            verdict = mpsc_pkg::VERDICT_LOW;
         end else begin
            verdict = mpsc_pkg::VERDICT_TRIVIAL_MIX;
         end
      end
   end

   assign ram_re    = final_beat;
   assign ram_raddr = sel[AW-1:0];

   mpsc_ram #(
      .WIDTH (32),
      .DEPTH (NUM_ADDRESSES)
   ) u_pair_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (pair),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // ------------------------------------------------------------------
   // Scan state registers; the final beat returns them to reset values.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset || final_beat) begin
         float_mask_ff  <= '0;
         zero_mask_ff   <= '0;
         unst_mask_ff   <= '0;
         other_mask_ff  <= '0;
         cand_mask_ff   <= '0;
         tmo_mask_ff    <= '0;
         float_cnt_ff   <= '0;
         zero_cnt_ff    <= '0;
         unst_cnt_ff    <= '0;
         other_cnt_ff   <= '0;
         cand_cnt_ff    <= '0;
         tmo_cnt_ff     <= '0;
         first_cand_ff  <= mpsc_pkg::NO_ADDRESS;
         first_other_ff <= mpsc_pkg::NO_ADDRESS;
         first_unst_ff  <= mpsc_pkg::NO_ADDRESS;
         total_ff       <= '0;
      end else begin
         float_mask_ff  <= float_mask_in;
         zero_mask_ff   <= zero_mask_in;
         unst_mask_ff   <= unst_mask_in;
         other_mask_ff  <= other_mask_in;
         cand_mask_ff   <= cand_mask_in;
         tmo_mask_ff    <= tmo_mask_in;
         float_cnt_ff   <= float_cnt_in;
         zero_cnt_ff    <= zero_cnt_in;
         unst_cnt_ff    <= unst_cnt_in;
         other_cnt_ff   <= other_cnt_in;
         cand_cnt_ff    <= cand_cnt_in;
         tmo_cnt_ff     <= tmo_cnt_in;
         first_cand_ff  <= first_cand_in;
         first_other_ff <= first_other_in;
         first_unst_ff  <= first_unst_in;
         total_ff       <= total_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage one: the finished scan waits for the RAM read data.
   // ------------------------------------------------------------------
   mpsc_pkg::rsp_type s1_rsp_ff;
   logic              s1_use_ram_ff;
   logic              s1_fwd_ff;
   logic [31:0]       s1_pair_ff;

   assign s1_valid_in = final_beat ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (final_beat) begin
         s1_rsp_ff.verdict         <= verdict;
         s1_rsp_ff.chosen_address  <= sel;
         s1_rsp_ff.chosen_id_high  <= (verdict == mpsc_pkg::VERDICT_LOW) ?
                                      mpsc_pkg::ID_ZERO : mpsc_pkg::ID_FLOATING;
         s1_rsp_ff.chosen_id_low   <= (verdict == mpsc_pkg::VERDICT_LOW) ?
                                      mpsc_pkg::ID_ZERO : mpsc_pkg::ID_FLOATING;
         s1_rsp_ff.candidate_count <= cand_cnt_in;
         s1_rsp_ff.timed_out_reads <= total_in;
         s1_rsp_ff.floating_mask   <= float_mask_in;
         s1_rsp_ff.zero_mask       <= zero_mask_in;
         s1_rsp_ff.unstable_mask   <= unst_mask_in;
         s1_rsp_ff.other_mask      <= other_mask_in;
         s1_rsp_ff.candidate_mask  <= cand_mask_in;
         s1_rsp_ff.timeout_mask    <= tmo_mask_in;
         s1_use_ram_ff             <= use_slot && (sel != mpsc_pkg::NO_ADDRESS);
         // The final beat may write the very entry it reads.
         s1_fwd_ff                 <= ram_we && (ram_waddr == ram_raddr);
         s1_pair_ff                <= pair;
      end
   end

   // ------------------------------------------------------------------
   // Output register.
   // ------------------------------------------------------------------
   mpsc_pkg::rsp_type rsp_data_ff, s1_out;
   logic [31:0]       s1_chosen_pair;

   assign s1_chosen_pair = s1_fwd_ff ? s1_pair_ff : ram_rdata;

   always_comb begin
      s1_out = s1_rsp_ff;
      if (s1_use_ram_ff) begin
         s1_out.chosen_id_high = s1_chosen_pair[31:16];
         s1_out.chosen_id_low  = s1_chosen_pair[15:0];
      end
   end

   assign rsp_valid_in = s1_move || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_data_ff <= s1_out;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hw/rtl/mpsc_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port; the read data is registered and holds
// until the next read. A read of the entry written in the same cycle
// returns the old contents.
// ----------------------------------------------------------------------------
module mpsc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MDIO PHY scan classifier testbench
// Drives address beats into the classifier, predicts the verdict of every
// scan with an independent model of the class ladder, and compares each
// result beat field by field. Directed scans reach every verdict and the
// count limits; random scans run under three sender and receiver idle
// mixes, and one phase holds the result channel off to back up the input.
// ----------------------------------------------------------------------------
module tb_top;
   import mpsc_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam logic [CSR_ADDR_W-1:0] EXPECTED_ID_ADDR = {CSR_IDX_EXPECTED_ID_HIGH, 2'b00};

   // Class and first-address slot indexes of the scan model.
   typedef enum int {
      CLS_FLOATING, CLS_ZERO, CLS_UNSTABLE, CLS_OTHER, CLS_CANDIDATE, CLS_TIMEOUT
   } scan_class_e;
   typedef enum int {SLOT_CANDIDATE, SLOT_OTHER, SLOT_UNSTABLE, SLOT_NONE} first_slot_e;

   // Shapes of random address beats.
   typedef enum int {
      KIND_TIMEOUT, KIND_UNSTABLE, KIND_FLOATING, KIND_ZERO, KIND_CANDIDATE,
      KIND_OTHER, KIND_NOISE
   } beat_kind_e;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Scan model state.
   logic [15:0] match_id = EXPECTED_RESET;
   logic [31:0] class_mask [6];
   logic [5:0]  class_count [6];
   logic [7:0]  first_address [3];
   logic [31:0] first_id_pair [3];
   logic [7:0]  timed_out_total;
   rsp_type     pending_verdicts [$];

   // Run bookkeeping.
   int error_count = 0;
   int beats_sent = 0;
   int scans_closed = 0;
   int verdicts_checked = 0;
   int verdicts_seen [9] = '{default: 0};
   int input_stall_cycles = 0;
   int cycle_count = 0;
   int send_idle_pct = 25;
   int rsp_idle_pct = 69;
   int hold_request = 0;
   int hold_left = 0;

   mdio_phy_scan_classifier_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Scan model
   // ------------------------------------------------------------------

   function automatic void clear_scan_state();
      int i;
      for (i = 0; i < 6; i++) begin
         class_mask[i]  = '0;
         class_count[i] = '0;
      end
      for (i = 0; i < 3; i++) begin
         first_address[i] = NO_ADDRESS;
         first_id_pair[i] = '0;
      end
      timed_out_total = '0;
   endfunction

   function automatic void mark_class(input scan_class_e cls, input logic [4:0] addr);
      class_mask[cls] = class_mask[cls] | (32'd1 << addr);
      if (class_count[cls] != COUNT_MAX) begin
         class_count[cls] = class_count[cls] + 6'd1;
      end
   endfunction

   function automatic void note_first(input first_slot_e slot, input logic [4:0] addr,
                                      input logic [31:0] pair);
      if (first_address[slot] == NO_ADDRESS) begin
         first_address[slot] = {3'b000, addr};
         first_id_pair[slot] = pair;
      end
   endfunction

   // Classify one accepted address beat; a beat marked final closes the
   // scan and queues the verdict that the block must return.
   function automatic void classify_address(input req_type beat);
      logic [15:0] reads [4];
      int          n_reads;
      int          n_timeouts;
      int          sum;
      int          i;
      logic        stable;
      logic [31:0] pair;
      first_slot_e slot;
      verdict_type verdict;
      rsp_type     result;

      reads[0] = beat.id_read_a;
      reads[1] = beat.id_read_b;
      reads[2] = beat.id_read_c;
      reads[3] = beat.id_read_d;
      n_reads = (READS_PER_ADDRESS_DEFAULT > MAX_READS) ? MAX_READS : READS_PER_ADDRESS_DEFAULT;
      n_timeouts = 0;
      stable = 1'b1;
      beats_sent++;

      if (beat.phy_address < NUM_ADDRESSES_DEFAULT) begin
         for (i = 0; i < n_reads; i++) begin
            if (beat.id_read_timeouts[i]) n_timeouts++;
            if (reads[i] != reads[0]) stable = 1'b0;
         end
         n_timeouts += beat.id_low_timeout;
         sum = timed_out_total + n_timeouts;
         timed_out_total = (sum > TOTAL_MAX) ? TOTAL_MAX : 8'(sum);
         pair = {reads[n_reads-1], beat.id_low_value};

         if (n_timeouts != 0) begin
            mark_class(CLS_TIMEOUT, beat.phy_address);
         end else if (!stable) begin
            mark_class(CLS_UNSTABLE, beat.phy_address);
            note_first(SLOT_UNSTABLE, beat.phy_address, pair);
         end else if (reads[0] == ID_FLOATING) begin
            mark_class(CLS_FLOATING, beat.phy_address);
         end else if (reads[0] == ID_ZERO) begin
            mark_class(CLS_ZERO, beat.phy_address);
         end else begin
            mark_class(CLS_OTHER, beat.phy_address);
            note_first(SLOT_OTHER, beat.phy_address, pair);
            if (reads[0] == match_id) begin
               mark_class(CLS_CANDIDATE, beat.phy_address);
               note_first(SLOT_CANDIDATE, beat.phy_address, pair);
            end
         end
      end

      if (!beat.final_address) return;

      // Verdict ladder, most specific answer first.
      slot = SLOT_NONE;
      if (class_count[CLS_CANDIDATE] == 6'd1) begin
         verdict = VERDICT_OK;
         slot = SLOT_CANDIDATE;
      end else if (class_count[CLS_CANDIDATE] > 6'd1) begin
         verdict = VERDICT_AMBIGUOUS;
         slot = SLOT_CANDIDATE;
      end else if (class_count[CLS_OTHER] == 6'd1) begin
         verdict = VERDICT_OTHER_ID;
         slot = SLOT_OTHER;
      end else if (class_count[CLS_OTHER] > 6'd1) begin
         verdict = VERDICT_MULTI_OTHER;
         slot = SLOT_OTHER;
      end else if (class_count[CLS_UNSTABLE] != 6'd0) begin
         verdict = VERDICT_UNSTABLE;
         slot = SLOT_UNSTABLE;
      end else if (class_count[CLS_TIMEOUT] != 6'd0) begin
         verdict = VERDICT_TIMEOUT;
      end else if (class_count[CLS_FLOATING] == NUM_ADDRESSES_DEFAULT) begin
         verdict = VERDICT_FLOATING;
      end else if (class_count[CLS_ZERO] == NUM_ADDRESSES_DEFAULT) begin
         verdict = VERDICT_LOW;
      end else begin
         verdict = VERDICT_TRIVIAL_MIX;
      end

      result = '0;
      result.verdict = verdict;
      result.chosen_address = (slot != SLOT_NONE) ? first_address[slot] : NO_ADDRESS;
      if (slot != SLOT_NONE && first_address[slot] != NO_ADDRESS) begin
         result.chosen_id_high = first_id_pair[slot][31:16];
         result.chosen_id_low  = first_id_pair[slot][15:0];
      end else if (verdict == VERDICT_LOW) begin
         result.chosen_id_high = ID_ZERO;
         result.chosen_id_low  = ID_ZERO;
      end else begin
         result.chosen_id_high = ID_FLOATING;
         result.chosen_id_low  = ID_FLOATING;
      end
      result.candidate_count = class_count[CLS_CANDIDATE];
      result.timed_out_reads = timed_out_total;
      result.floating_mask   = class_mask[CLS_FLOATING];
      result.zero_mask       = class_mask[CLS_ZERO];
      result.unstable_mask   = class_mask[CLS_UNSTABLE];
      result.other_mask      = class_mask[CLS_OTHER];
      result.candidate_mask  = class_mask[CLS_CANDIDATE];
      result.timeout_mask    = class_mask[CLS_TIMEOUT];
      pending_verdicts.push_back(result);
      scans_closed++;
      clear_scan_state();
   endfunction

   // ------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   function automatic void check_verdict(input rsp_type got);
      rsp_type want;
      if (pending_verdicts.size() == 0) begin
         $display("%0t ns: result beat with no scan pending, actual %0h", $time, got);
         error_count++;
         return;
      end
      want = pending_verdicts.pop_front();
      verdicts_checked++;
      if (want.verdict <= VERDICT_TRIVIAL_MIX) verdicts_seen[want.verdict]++;
      check_field("verdict", want.verdict, got.verdict);
      check_field("chosen_address", want.chosen_address, got.chosen_address);
      check_field("chosen_id_high", want.chosen_id_high, got.chosen_id_high);
      check_field("chosen_id_low", want.chosen_id_low, got.chosen_id_low);
      check_field("candidate_count", want.candidate_count, got.candidate_count);
      check_field("timed_out_reads", want.timed_out_reads, got.timed_out_reads);
      check_field("floating_mask", want.floating_mask, got.floating_mask);
      check_field("zero_mask", want.zero_mask, got.zero_mask);
      check_field("unstable_mask", want.unstable_mask, got.unstable_mask);
      check_field("other_mask", want.other_mask, got.other_mask);
      check_field("candidate_mask", want.candidate_mask, got.candidate_mask);
      check_field("timeout_mask", want.timeout_mask, got.timeout_mask);
   endfunction

   // Every result beat taken is compared with the oldest scan verdict.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_verdict(rsp_data);
   end

   // Receiver stalls: a requested hold-off first, otherwise at the phase's rate.
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < rsp_idle_pct);
      end
   end

   // Run watchdog and input back-pressure count.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (req_valid && req_stall) input_stall_cycles <= input_stall_cycles + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t ns: run stopped after %0d cycles", $time, CYCLE_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Offer one address beat after a random idle gap and hold it until taken.
   // Entered and left at a falling edge.
   task automatic send_address(input req_type beat);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      classify_address(beat);
      @(negedge clock);
   endtask

   // Wait until every closed scan has returned, then let the pipeline settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // One register transfer: setup cycle, then access cycle until ready.
   task automatic csr_access(input logic is_write, input logic [15:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= EXPECTED_ID_ADDR;
      csr_pwdata  <= {16'h0000, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (is_write) match_id = value;
      else check_field("expected_id_high readback", {16'h0000, match_id}, csr_prdata);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_match_id(input logic [15:0] value);
      csr_access(1'b1, value);
      csr_access(1'b0, 16'h0000);
   endtask

   function automatic req_type stable_beat(input logic [4:0] addr, input logic [15:0] id_high,
                                           input logic [15:0] id_low, input logic last);
      req_type beat;
      beat = '0;
      beat.phy_address   = addr;
      beat.id_read_a     = id_high;
      beat.id_read_b     = id_high;
      beat.id_read_c     = id_high;
      beat.id_read_d     = id_high;
      beat.id_low_value  = id_low;
      beat.final_address = last;
      return beat;
   endfunction

   function automatic beat_kind_e pick_kind();
      int roll;
      roll = $urandom_range(99, 0);
      if (roll < 10) return KIND_TIMEOUT;
      if (roll < 24) return KIND_UNSTABLE;
      if (roll < 38) return KIND_FLOATING;
      if (roll < 52) return KIND_ZERO;
      if (roll < 70) return KIND_CANDIDATE;
      if (roll < 92) return KIND_OTHER;
      return KIND_NOISE;
   endfunction

   function automatic req_type make_beat(input logic [4:0] addr, input logic last,
                                         input beat_kind_e kind);
      req_type     beat;
      logic [15:0] value;
      logic [15:0] flip;
      value = 16'($urandom);
      beat  = stable_beat(addr, value, 16'($urandom), last);
      case (kind)
         KIND_TIMEOUT: begin
            beat.id_read_timeouts = 4'($urandom);
            beat.id_low_timeout   = 1'($urandom);
            if (beat.id_read_timeouts == 4'h0 && !beat.id_low_timeout)
               beat.id_read_timeouts = 4'b0001 << $urandom_range(3, 0);
         end
         KIND_UNSTABLE: begin
            flip = 16'($urandom_range(65535, 1));
            case ($urandom_range(3, 0))
               0: beat.id_read_a = value ^ flip;
               1: beat.id_read_b = value ^ flip;
               2: beat.id_read_c = value ^ flip;
               default: beat.id_read_d = value ^ flip;
            endcase
         end
         KIND_FLOATING: beat = stable_beat(addr, ID_FLOATING, 16'($urandom), last);
         KIND_ZERO: beat = stable_beat(addr, ID_ZERO, 16'($urandom), last);
         KIND_CANDIDATE: beat = stable_beat(addr, match_id, 16'($urandom), last);
         KIND_OTHER: begin
         end
         default: begin
            // Noise: all read and timeout fields random, plus a possible early final mark.
            beat.id_read_a        = 16'($urandom);
            beat.id_read_b        = 16'($urandom);
            beat.id_read_c        = 16'($urandom);
            beat.id_read_d        = 16'($urandom);
            beat.id_read_timeouts = 4'($urandom);
            beat.id_low_timeout   = 1'($urandom);
            beat.final_address    = last | ($urandom_range(15, 0) == 0);
         end
      endcase
      return beat;
   endfunction

   // One random scan, always closed by a final beat.
   task automatic send_random_scan();
      int         shape;
      int         length;
      int         k;
      int         responders;
      int         pick_a;
      int         pick_b;
      logic [4:0] start;
      beat_kind_e background;
      beat_kind_e kind;
      shape = $urandom_range(99, 0);
      if (shape < 60) begin
         // Partial scan over a window of addresses with mixed classes.
         length = $urandom_range(32, 1);
         start  = 5'($urandom);
         for (k = 0; k < length; k++)
            send_address(make_beat(5'(start + k), k == length - 1, pick_kind()));
      end else if (shape < 85) begin
         // Full scan of an idle bus with at most two responders.
         background = ($urandom_range(1, 0) != 0) ? KIND_FLOATING : KIND_ZERO;
         responders = $urandom_range(2, 0);
         pick_a = $urandom_range(31, 0);
         pick_b = $urandom_range(31, 0);
         for (k = 0; k < NUM_ADDRESSES_DEFAULT; k++) begin
            kind = background;
            if ((responders > 0 && k == pick_a) || (responders > 1 && k == pick_b))
               kind = pick_kind();
            send_address(make_beat(5'(k), k == NUM_ADDRESSES_DEFAULT - 1, kind));
         end
      end else begin
         // Noise with random addresses and stray final marks.
         length = $urandom_range(16, 1);
         for (k = 0; k < length; k++)
            send_address(make_beat(5'($urandom), k == length - 1, KIND_NOISE));
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   task automatic test_reset_values();
      csr_access(1'b0, 16'h0000);
   endtask

   // Short scans that reach every verdict below the full-bus ones.
   task automatic test_directed_verdicts();
      req_type beat;
      send_address(stable_beat(5'd31, 16'd7, 16'hFFFF, 1'b1));

      beat = stable_beat(5'd0, 16'hFFFF, 16'hFFFF, 1'b0);
      beat.id_read_timeouts = 4'hF;
      beat.id_low_timeout   = 1'b1;
      send_address(beat);
      beat = stable_beat(5'd1, 16'h0000, 16'h0000, 1'b0);
      beat.id_read_d = 16'hFFFF;
      send_address(beat);
      send_address(stable_beat(5'd2, 16'hFFFF, 16'hFFFF, 1'b0));
      send_address(stable_beat(5'd3, 16'h0000, 16'h0000, 1'b0));
      send_address(stable_beat(5'd4, 16'h1234, 16'h5678, 1'b0));
      send_address(stable_beat(5'd5, 16'd7, 16'hC0DE, 1'b0));
      send_address(stable_beat(5'd6, 16'd7, 16'h0001, 1'b1));

      send_address(stable_beat(5'd9, 16'h8001, 16'h00FF, 1'b1));
      send_address(stable_beat(5'd10, 16'h0022, 16'h0101, 1'b0));
      send_address(stable_beat(5'd20, 16'h0033, 16'h0202, 1'b1));

      // Unstable only: the stored ID is the last register 2 read.
      beat = stable_beat(5'd17, 16'hAAAA, 16'h5555, 1'b1);
      beat.id_read_a = 16'h5555;
      send_address(beat);

      // A timed-out register 3 read alone makes the address a timeout.
      beat = stable_beat(5'd12, 16'd7, 16'd7, 1'b1);
      beat.id_low_timeout = 1'b1;
      send_address(beat);

      // Repeated address counts twice but sets one mask bit.
      send_address(stable_beat(5'd3, 16'd7, 16'h0003, 1'b0));
      send_address(stable_beat(5'd3, 16'd7, 16'h0004, 1'b1));

      send_address(stable_beat(5'd8, 16'hFFFF, 16'hFFFF, 1'b1));
      drain_results();
   endtask

   // Whole-bus scans: all floating, then all zero.
   task automatic test_uniform_scans();
      int k;
      for (k = 0; k < NUM_ADDRESSES_DEFAULT; k++)
         send_address(make_beat(5'(k), k == NUM_ADDRESSES_DEFAULT - 1, KIND_FLOATING));
      for (k = 0; k < NUM_ADDRESSES_DEFAULT; k++)
         send_address(make_beat(5'(k), k == NUM_ADDRESSES_DEFAULT - 1, KIND_ZERO));
      drain_results();
   endtask

   // An expected ID of zero or all ones never yields a candidate.
   task automatic test_expected_id_extremes();
      set_match_id(16'h0000);
      send_address(stable_beat(5'd0, 16'h0000, 16'h0000, 1'b0));
      send_address(stable_beat(5'd1, 16'h0007, 16'h1111, 1'b0));
      send_address(stable_beat(5'd2, 16'h0000, 16'hFFFF, 1'b1));
      drain_results();
      set_match_id(16'hFFFF);
      send_address(stable_beat(5'd0, 16'hFFFF, 16'hFFFF, 1'b1));
      drain_results();
      set_match_id(16'h0001);
      send_address(stable_beat(5'd5, 16'h0001, 16'hABCD, 1'b1));
      drain_results();
   endtask

   // Long scans that saturate the class count and the timed-out read total.
   task automatic test_count_limits();
      req_type beat;
      int      k;
      set_match_id(16'h00A5);
      for (k = 0; k < 70; k++)
         send_address(stable_beat(5'(k), match_id, 16'(k), k == 69));
      for (k = 0; k < 60; k++) begin
         beat = make_beat(5'(k), k == 59, KIND_TIMEOUT);
         beat.id_read_timeouts = 4'hF;
         beat.id_low_timeout   = 1'b1;
         send_address(beat);
      end
      drain_results();
   endtask

   // Hold the result channel off while short scans keep arriving.
   task automatic test_backpressure();
      int k;
      int n;
      int length;
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      hold_request  = 400;
      for (n = 0; n < 25; n++) begin
         length = $urandom_range(3, 1);
         for (k = 0; k < length; k++)
            send_address(make_beat(5'($urandom), k == length - 1, pick_kind()));
      end
      drain_results();
   endtask

   task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                      input int beat_count);
      int phase_end;
      if ($urandom_range(3, 0) == 0) set_match_id(16'($urandom_range(15, 1)));
      else set_match_id(16'($urandom));
      send_idle_pct = sender_pct;
      rsp_idle_pct  = receiver_pct;
      phase_end = beats_sent + beat_count;
      while (beats_sent < phase_end) send_random_scan();
      drain_results();
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      clear_scan_state();

      test_reset_values();
      test_directed_verdicts();
      test_uniform_scans();
      test_expected_id_extremes();
      test_count_limits();
      test_backpressure();
      test_random_traffic(25, 69, 430);
      test_random_traffic(69, 25, 430);
      test_random_traffic(0, 0, 430);

      $display("Ran %0d address beats in %0d scans, %0d verdicts compared; input stalled %0d cycles.",
               beats_sent, scans_closed, verdicts_checked, input_stall_cycles);
      $display("Verdicts: ok %0d, ambiguous %0d, other %0d, multi other %0d, unstable %0d, %s %0d, %s %0d, %s %0d, %s %0d.",
               verdicts_seen[0], verdicts_seen[1], verdicts_seen[2], verdicts_seen[3],
               verdicts_seen[4], "timeout", verdicts_seen[5], "floating", verdicts_seen[6],
               "low", verdicts_seen[7], "mixed", verdicts_seen[8]);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

[mdio_phy_scan_classifier_core.f]
hw/rtl/mpsc_pkg.sv
hw/rtl/mpsc_ram.sv
hw/rtl/mdio_phy_scan_classifier_core.sv
dv/tb_top.sv
